// ===== sv/bir_pkg.sv =====
// Shared widths, codes and reset values of the bilinear image resizer.
`default_nettype none

package bir_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 16;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int RATIO_W    = 26;
    localparam int POS_W      = COORD_W + RATIO_W;
    localparam int CALC_W     = 2 * DIM_W + 1;
    localparam int WGT_W      = 8;
    localparam int WGT1_W     = WGT_W + 1;
    localparam int PART_W     = WGT1_W + PIX_W;
    localparam int ACC_W      = WGT1_W + PART_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RATIO_W;

    // Weight scale: u + u1 = 1.0 in 8-bit weights
    localparam logic [WGT1_W-1:0] WGT_ONE = WGT1_W'(1 << WGT_W);
    // Smallest destination size that produces output
    localparam logic [DIM_W-1:0] MIN_DST = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

    // Item actions
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_X_RATIO    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_Y_RATIO    = CFG_IDX_W'(5);

    // Register reset values
    localparam logic [DIM_W-1:0]   SRC_WIDTH_RST  = DIM_W'(256);
    localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST = DIM_W'(256);
    localparam logic [DIM_W-1:0]   DST_WIDTH_RST  = DIM_W'(480);
    localparam logic [DIM_W-1:0]   DST_HEIGHT_RST = DIM_W'(480);
    localparam logic [RATIO_W-1:0] X_RATIO_RST    = RATIO_W'(34952);
    localparam logic [RATIO_W-1:0] Y_RATIO_RST    = RATIO_W'(34952);

    // Parameter defaults
    localparam int SRC_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

// ===== sv/bir_req_if.sv =====
// Request channel: pixel writes and compute items.
`default_nettype none

interface bir_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [bir_pkg::ADDR_W-1:0]    pixel_addr;
    logic [bir_pkg::PIX_W-1:0]     pixel_value;
    logic [bir_pkg::COORD_W-1:0]   out_x;
    logic [bir_pkg::COORD_W-1:0]   out_y;

    modport source (output valid, action, pixel_addr, pixel_value, out_x, out_y,
                    input ready);
    modport sink   (input valid, action, pixel_addr, pixel_value, out_x, out_y,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/bir_rsp_if.sv =====
// Result channel: interpolated destination pixels.
`default_nettype none

interface bir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bir_pkg::PIX_W-1:0]     out_pixel;
    logic [bir_pkg::COORD_W-1:0]   res_x;
    logic [bir_pkg::COORD_W-1:0]   res_y;

    modport source (output valid, out_pixel, res_x, res_y, input ready);
    modport sink   (input valid, out_pixel, res_x, res_y, output ready);
endinterface

`default_nettype wire

// ===== sv/bir_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface bir_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bir_pkg::CFG_IDX_W-1:0]   index;
    logic [bir_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/bir_mem.sv =====
// Source image memory: one write port, two registered read ports.
`default_nettype none

module bir_mem #(
    parameter int DEPTH = bir_pkg::SRC_DEPTH_DEF,
    parameter int AW    = $clog2(bir_pkg::SRC_DEPTH_DEF)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [bir_pkg::PIX_W-1:0]  wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr_a,
    input  wire logic [AW-1:0]              raddr_b,
    output logic      [bir_pkg::PIX_W-1:0]  rdata_a,
    output logic      [bir_pkg::PIX_W-1:0]  rdata_b
);

    logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bir_pkg::PIX_W-1:0] rdata_a_reg;
    logic [bir_pkg::PIX_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while the consuming stage stalls
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== sv/bilinear_image_resize.sv =====
// Top level of the grayscale bilinear image resizer.
//
//  channel | dir | handshake       | transaction carries
//  --------+-----+-----------------+--------------------------------------------------
//  req     | in  | valid / ready   | action, pixel_addr, pixel_value, out_x, out_y
//  rsp     | out | valid / ready   | out_pixel, res_x, res_y
//  cfg     | in  | valid / ready   | index, data (register write, always ready)
//
//  One request transaction per clock sustained while rsp accepts results. The rate
//  is set by the image memory: two copies (upper and lower neighbor rows), each with
//  two read ports, give all four neighbors per cycle. Reset clears the stage valid
//  bits and loads the configuration registers with their reset values; the image
//  memory is not cleared. Each of the six stages advances when the next one is empty
//  or moving, so bubbles close up and requests are taken while a result waits on rsp.
`default_nettype none

module bilinear_image_resize #(
    parameter int SRC_DEPTH = bir_pkg::SRC_DEPTH_DEF,
    parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bir_req_if.sink    req,
    bir_rsp_if.source  rsp,
    bir_cfg_if.sink    cfg
);

    localparam int MEM_AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
    localparam int PIX_W  = bir_pkg::PIX_W;
    localparam int COORD_W = bir_pkg::COORD_W;
    localparam int DIM_W  = bir_pkg::DIM_W;
    localparam int RATIO_W = bir_pkg::RATIO_W;
    localparam int POS_W  = bir_pkg::POS_W;
    localparam int CALC_W = bir_pkg::CALC_W;
    localparam int WGT_W  = bir_pkg::WGT_W;
    localparam int WGT1_W = bir_pkg::WGT1_W;
    localparam int PART_W = bir_pkg::PART_W;
    localparam int ACC_W  = bir_pkg::ACC_W;
    localparam logic [CALC_W-1:0] DEPTH_LIM = CALC_W'(SRC_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers; a zero source size is stored as one
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   src_w_reg;
    logic [DIM_W-1:0]   src_h_reg;
    logic [DIM_W-1:0]   dst_w_reg;
    logic [DIM_W-1:0]   dst_h_reg;
    logic [RATIO_W-1:0] x_ratio_reg;
    logic [RATIO_W-1:0] y_ratio_reg;
    logic [DIM_W-1:0]   cfg_dim;

    assign cfg.ready = 1'b1;
    assign cfg_dim   = cfg.data[DIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= bir_pkg::SRC_WIDTH_RST;
            src_h_reg   <= bir_pkg::SRC_HEIGHT_RST;
            dst_w_reg   <= bir_pkg::DST_WIDTH_RST;
            dst_h_reg   <= bir_pkg::DST_HEIGHT_RST;
            x_ratio_reg <= bir_pkg::X_RATIO_RST;
            y_ratio_reg <= bir_pkg::Y_RATIO_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bir_pkg::REG_SRC_WIDTH:
                    src_w_reg <= (cfg_dim == '0) ? bir_pkg::DIM_ONE : cfg_dim;
                bir_pkg::REG_SRC_HEIGHT:
                    src_h_reg <= (cfg_dim == '0) ? bir_pkg::DIM_ONE : cfg_dim;
                bir_pkg::REG_DST_WIDTH:  dst_w_reg   <= cfg_dim;
                bir_pkg::REG_DST_HEIGHT: dst_h_reg   <= cfg_dim;
                bir_pkg::REG_X_RATIO:    x_ratio_reg <= cfg.data[RATIO_W-1:0];
                bir_pkg::REG_Y_RATIO:    y_ratio_reg <= cfg.data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or its item moves on
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || rsp.ready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign req.ready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: qualify the request and form the source positions
    // ------------------------------------------------------------------
    logic              req_fire;
    logic              wr_ok;
    logic              cmp_ok;
    logic [CALC_W-1:0] req_addr_ext;

    logic              s1_write_reg;
    logic [MEM_AW-1:0] s1_waddr_reg;
    logic [PIX_W-1:0]  s1_wdata_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [POS_W-1:0]  s1_sx_reg;
    logic [POS_W-1:0]  s1_sy_reg;

    assign req_fire     = req.valid && rdy1;
    assign req_addr_ext = CALC_W'(req.pixel_addr);

    // Drop writes past memory and computes outside the destination or below MIN_DST
    assign wr_ok  = (req.action == bir_pkg::ACT_WRITE) && (req_addr_ext < DEPTH_LIM);
    assign cmp_ok = (req.action == bir_pkg::ACT_COMPUTE)
                 && (dst_w_reg >= bir_pkg::MIN_DST) && (dst_h_reg >= bir_pkg::MIN_DST)
                 && (DIM_W'(req.out_x) < dst_w_reg) && (DIM_W'(req.out_y) < dst_h_reg);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_write_reg <= (req.action == bir_pkg::ACT_WRITE);
            s1_waddr_reg <= req_addr_ext[MEM_AW-1:0];
            s1_wdata_reg <= req.pixel_value;
            s1_x_reg     <= req.out_x;
            s1_y_reg     <= req.out_y;
            s1_sx_reg    <= POS_W'(req.out_x) * POS_W'(x_ratio_reg);
            s1_sy_reg    <= POS_W'(req.out_y) * POS_W'(y_ratio_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: split positions into clamped integer part and 8-bit weight
    // ------------------------------------------------------------------
    logic [POS_W-1:0] ipx;
    logic [POS_W-1:0] ipy;
    logic [DIM_W-1:0] w_m1;
    logic [DIM_W-1:0] h_m1;
    logic [DIM_W-1:0] ix_next;
    logic [DIM_W-1:0] iy_next;

    logic              s2_write_reg;
    logic [MEM_AW-1:0] s2_waddr_reg;
    logic [PIX_W-1:0]  s2_wdata_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [COORD_W-1:0] s2_y_reg;
    logic [DIM_W-1:0]  s2_ix_reg;
    logic [DIM_W-1:0]  s2_iy_reg;
    logic [WGT_W-1:0]  s2_u_reg;
    logic [WGT_W-1:0]  s2_v_reg;
    logic              s2_right_reg;
    logic              s2_low_reg;

    assign ipx  = s1_sx_reg >> FRAC_BITS;
    assign ipy  = s1_sy_reg >> FRAC_BITS;
    assign w_m1 = src_w_reg - bir_pkg::DIM_ONE;
    assign h_m1 = src_h_reg - bir_pkg::DIM_ONE;
    // Clamp a position past the image to the last column or row
    assign ix_next = (ipx > POS_W'(w_m1)) ? w_m1 : ipx[DIM_W-1:0];
    assign iy_next = (ipy > POS_W'(h_m1)) ? h_m1 : ipy[DIM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_write_reg <= s1_write_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_wdata_reg <= s1_wdata_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_ix_reg    <= ix_next;
            s2_iy_reg    <= iy_next;
            s2_u_reg     <= WGT_W'(s1_sx_reg >> (FRAC_BITS - WGT_W));
            s2_v_reg     <= WGT_W'(s1_sy_reg >> (FRAC_BITS - WGT_W));
            s2_right_reg <= (ix_next < w_m1);
            s2_low_reg   <= (iy_next < h_m1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: linear address of the top-left neighbor
    // ------------------------------------------------------------------
    logic              s3_write_reg;
    logic [MEM_AW-1:0] s3_waddr_reg;
    logic [PIX_W-1:0]  s3_wdata_reg;
    logic [COORD_W-1:0] s3_x_reg;
    logic [COORD_W-1:0] s3_y_reg;
    logic [CALC_W-1:0] s3_a00_reg;
    logic [WGT_W-1:0]  s3_u_reg;
    logic [WGT_W-1:0]  s3_v_reg;
    logic              s3_right_reg;
    logic              s3_low_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_write_reg <= s2_write_reg;
            s3_waddr_reg <= s2_waddr_reg;
            s3_wdata_reg <= s2_wdata_reg;
            s3_x_reg     <= s2_x_reg;
            s3_y_reg     <= s2_y_reg;
            s3_a00_reg   <= CALC_W'(s2_iy_reg) * CALC_W'(src_w_reg) + CALC_W'(s2_ix_reg);
            s3_u_reg     <= s2_u_reg;
            s3_v_reg     <= s2_v_reg;
            s3_right_reg <= s2_right_reg;
            s3_low_reg   <= s2_low_reg;
        end
    end

    // ------------------------------------------------------------------
    // Memory access: writes and reads leave stage 3 in request order, so a
    // compute always sees every earlier write; no forwarding is needed.
    // At the last column or row the neighbor repeats the near one.
    // ------------------------------------------------------------------
    logic [CALC_W-1:0] a01;
    logic [CALC_W-1:0] a10;
    logic [CALC_W-1:0] a11;
    logic              mem_we;
    logic              mem_re;
    logic [PIX_W-1:0]  p00_raw, p01_raw, p10_raw, p11_raw;

    assign a01 = s3_right_reg ? s3_a00_reg + CALC_W'(1) : s3_a00_reg;
    assign a10 = s3_low_reg   ? s3_a00_reg + CALC_W'(src_w_reg) : s3_a00_reg;
    assign a11 = s3_right_reg ? a10 + CALC_W'(1) : a10;

    assign mem_we = rdy4 && v3_reg && s3_write_reg;
    assign mem_re = rdy4 && v3_reg && !s3_write_reg;

    // Upper neighbor row
    bir_mem #(
        .DEPTH (SRC_DEPTH),
        .AW    (MEM_AW)
    ) u_mem_top (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (s3_waddr_reg),
        .wdata   (s3_wdata_reg),
        .re      (mem_re),
        .raddr_a (s3_a00_reg[MEM_AW-1:0]),
        .raddr_b (a01[MEM_AW-1:0]),
        .rdata_a (p00_raw),
        .rdata_b (p01_raw)
    );

    // Lower neighbor row: identical copy of the image
    bir_mem #(
        .DEPTH (SRC_DEPTH),
        .AW    (MEM_AW)
    ) u_mem_bot (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (s3_waddr_reg),
        .wdata   (s3_wdata_reg),
        .re      (mem_re),
        .raddr_a (a10[MEM_AW-1:0]),
        .raddr_b (a11[MEM_AW-1:0]),
        .rdata_a (p10_raw),
        .rdata_b (p11_raw)
    );

    // ------------------------------------------------------------------
    // Stage 4: read data arrives; side data and out-of-range flags follow
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] s4_x_reg;
    logic [COORD_W-1:0] s4_y_reg;
    logic [WGT_W-1:0]  s4_u_reg;
    logic [WGT_W-1:0]  s4_v_reg;
    logic [3:0]        s4_oob_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= s3_y_reg;
            s4_u_reg   <= s3_u_reg;
            s4_v_reg   <= s3_v_reg;
            s4_oob_reg <= {a11 >= DEPTH_LIM, a10 >= DEPTH_LIM,
                           a01 >= DEPTH_LIM, s3_a00_reg >= DEPTH_LIM};
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: horizontal blend of both rows
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  p00, p01, p10, p11;
    logic [WGT1_W-1:0] u1;

    logic [COORD_W-1:0] s5_x_reg;
    logic [COORD_W-1:0] s5_y_reg;
    logic [WGT_W-1:0]  s5_v_reg;
    logic [PART_W-1:0] s5_top_reg;
    logic [PART_W-1:0] s5_bot_reg;

    // Drop neighbors that lie past the memory to zero
    assign p00 = s4_oob_reg[0] ? '0 : p00_raw;
    assign p01 = s4_oob_reg[1] ? '0 : p01_raw;
    assign p10 = s4_oob_reg[2] ? '0 : p10_raw;
    assign p11 = s4_oob_reg[3] ? '0 : p11_raw;
    assign u1  = bir_pkg::WGT_ONE - WGT1_W'(s4_u_reg);

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_x_reg   <= s4_x_reg;
            s5_y_reg   <= s4_y_reg;
            s5_v_reg   <= s4_v_reg;
            s5_top_reg <= PART_W'(s4_u_reg) * PART_W'(p01) + PART_W'(u1) * PART_W'(p00);
            s5_bot_reg <= PART_W'(s4_u_reg) * PART_W'(p11) + PART_W'(u1) * PART_W'(p10);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: vertical blend into the output register
    // ------------------------------------------------------------------
    logic [WGT1_W-1:0] v1;
    logic [ACC_W-1:0]  acc;

    logic [PIX_W-1:0]   s6_pix_reg;
    logic [COORD_W-1:0] s6_x_reg;
    logic [COORD_W-1:0] s6_y_reg;

    assign v1  = bir_pkg::WGT_ONE - WGT1_W'(s5_v_reg);
    assign acc = ACC_W'(v1) * ACC_W'(s5_top_reg) + ACC_W'(s5_v_reg) * ACC_W'(s5_bot_reg);

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            s6_pix_reg <= acc[2*WGT_W +: PIX_W];
            s6_x_reg   <= s5_x_reg;
            s6_y_reg   <= s5_y_reg;
        end
    end

    assign rsp.valid     = v6_reg;
    assign rsp.out_pixel = s6_pix_reg;
    assign rsp.res_x     = s6_x_reg;
    assign rsp.res_y     = s6_y_reg;

    // ------------------------------------------------------------------
    // Stage valid bits; a write retires at stage 3
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req_fire && (wr_ok || cmp_ok);
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg && !s3_write_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

endmodule

`default_nettype wire
